// ----- sv/ert_pkg.sv -----
package ert_pkg;

	localparam int unsigned DEF_TABLE_ENTRIES = 16;
	localparam int unsigned EPOCH_W = 32;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned POS_W = 4;

	typedef enum logic [1:0] {
		KIND_CHECK  = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_REMOVE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] start;
		logic [COUNT_W-1:0] len;
	} entry_t;

endpackage

// ----- sv/ert_chan_if.sv -----
interface ert_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic [ert_pkg::EPOCH_W-1:0]   start_epoch;
	logic [ert_pkg::COUNT_W-1:0]   epoch_count;

	modport source (output valid, output kind, output start_epoch, output epoch_count,
		input ready);
	modport sink (input valid, input kind, input start_epoch, input epoch_count,
		output ready);
endinterface

interface ert_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [1:0]                    status;
	logic [ert_pkg::POS_W-1:0]     found_position;
	logic [ert_pkg::COUNT_W-1:0]   found_count;

	modport source (output valid, output hit, output status, output found_position,
		output found_count, input ready);
	modport sink (input valid, input hit, input status, input found_position,
		input found_count, output ready);
endinterface

// ----- sv/ert_cmp.sv -----
module ert_cmp (
	input  ert_pkg::entry_t              entry,
	input  ert_pkg::kind_t               kind,
	input  logic [ert_pkg::EPOCH_W-1:0]  key,
	input  logic [ert_pkg::COUNT_W-1:0]  cnt,
	output logic                         match
);

	logic [ert_pkg::EPOCH_W-1:0] lo;
	logic [ert_pkg::EPOCH_W:0]   end_a;
	logic [ert_pkg::EPOCH_W:0]   end_b;
	logic [ert_pkg::EPOCH_W:0]   hi;
	logic                        overlap;

	always_comb begin
		lo      = (entry.start > key) ? entry.start : key;
		end_a   = {1'b0, entry.start} + {{(ert_pkg::EPOCH_W + 1 - ert_pkg::COUNT_W){1'b0}}, entry.len};
		end_b   = {1'b0, key} + {{(ert_pkg::EPOCH_W + 1 - ert_pkg::COUNT_W){1'b0}}, cnt};
		hi      = (end_a < end_b) ? end_a : end_b;
		overlap = {1'b0, lo} < hi;
		match   = (kind == ert_pkg::KIND_CHECK) ? overlap : (entry.start == key);
	end

endmodule

// ----- sv/epoch_range_table_unit.sv -----
// Epoch range table: a newest-first table of up to TABLE_ENTRIES ranges (32-bit start,
// 16-bit count) held in a single-port-write, single-port-read memory, with one result beat
// per request beat. The memory moves one entry per cycle and the one compare unit checks
// one entry per cycle. With n entries stored, an overlap check or lookup stops at the first
// hit, an insert moves all n entries down one place, and a remove scans to the match at
// position p and then moves the n - p - 1 entries behind it up. The table holds no reset
// pass; it is usable straight after reset. A request is taken only when the sequencer is
// idle; the finished result sits in an output register, so the next request may be taken
// while it waits.
module epoch_range_table_unit #(
	parameter int unsigned TABLE_ENTRIES = ert_pkg::DEF_TABLE_ENTRIES
) (
	input  logic      clk,
	input  logic      arst_n,
	ert_req_if.sink   req,
	ert_rsp_if.source rsp
);

	localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] OCC_FULL = CW'(TABLE_ENTRIES);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_MOVE = 5'b00100,
		ST_PUT  = 5'b01000,
		ST_RESP = 5'b10000
	} state_t;

	state_t                       state_q;
	ert_pkg::kind_t               kind_q;
	logic [ert_pkg::EPOCH_W-1:0]  key_q;
	logic [ert_pkg::COUNT_W-1:0]  cnt_q;
	logic [CW-1:0]                occ_q;
	logic [CW-1:0]                rd_idx_q;
	logic                         cmp_vld_s1;
	logic [IW-1:0]                cmp_idx_s1;
	logic [IW-1:0]                src_q;
	logic                         mv_issue_q;
	logic                         mv_vld_s1;
	logic [IW-1:0]                mv_dst_s1;
	logic                         hit_q;
	ert_pkg::status_t             status_q;
	logic [IW-1:0]                pos_q;
	logic [ert_pkg::COUNT_W-1:0]  fcount_q;

	logic                         out_vld_q;
	logic                         out_hit_q;
	logic [1:0]                   out_status_q;
	logic [ert_pkg::POS_W-1:0]    out_pos_q;
	logic [ert_pkg::COUNT_W-1:0]  out_count_q;

	ert_pkg::entry_t              mem_q [TABLE_ENTRIES];
	ert_pkg::entry_t              rd_data_s1;
	ert_pkg::entry_t              wr_data;
	logic [IW-1:0]                rd_addr;
	logic [IW-1:0]                wr_addr;
	logic                         wr_en;

	logic                         match;
	logic [CW-1:0]                last_idx;
	logic                         cmp_last;
	logic                         scan_issue;
	logic                         ins_dir;
	logic                         mv_end;
	logic                         out_load;
	logic [IW+ert_pkg::POS_W-1:0] pos_wide;
	ert_pkg::kind_t               req_kind;

	ert_cmp u_cmp (
		.entry (rd_data_s1),
		.kind  (kind_q),
		.key   (key_q),
		.cnt   (cnt_q),
		.match (match)
	);

	always_comb begin
		req_kind   = ert_pkg::kind_t'(req.kind);
		last_idx   = occ_q - CW'(1);
		cmp_last   = CW'(cmp_idx_s1) == last_idx;
		scan_issue = (rd_idx_q < occ_q) && !(cmp_vld_s1 && (match || cmp_last));
		ins_dir    = kind_q == ert_pkg::KIND_INSERT;
		mv_end     = ins_dir ? (src_q == '0) : (src_q == last_idx[IW-1:0]);
		out_load   = (state_q == ST_RESP) && (!out_vld_q || rsp.ready);
		pos_wide   = {{ert_pkg::POS_W{1'b0}}, pos_q};
		rd_addr    = (state_q == ST_MOVE) ? src_q : rd_idx_q[IW-1:0];
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = rd_data_s1;
		if (state_q == ST_MOVE && mv_vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = mv_dst_s1;
		end else if (state_q == ST_PUT) begin
			wr_en   = 1'b1;
			wr_data = '{start: key_q, len: cnt_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			occ_q      <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			mv_issue_q <= 1'b0;
			mv_vld_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						rd_idx_q <= '0;
						if (req_kind == ert_pkg::KIND_INSERT) begin
							if (occ_q == OCC_FULL) begin
								state_q <= ST_RESP;
							end else if (occ_q == '0) begin
								state_q <= ST_PUT;
							end else begin
								mv_issue_q <= 1'b1;
								state_q    <= ST_MOVE;
							end
						end else if (occ_q == '0) begin
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= scan_issue;
					if (scan_issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (cmp_vld_s1 && match) begin
						cmp_vld_s1 <= 1'b0;
						if (kind_q == ert_pkg::KIND_REMOVE) begin
							if (cmp_last) begin
								occ_q   <= occ_q - CW'(1);
								state_q <= ST_RESP;
							end else begin
								mv_issue_q <= 1'b1;
								state_q    <= ST_MOVE;
							end
						end else begin
							state_q <= ST_RESP;
						end
					end else if (cmp_vld_s1 && cmp_last) begin
						cmp_vld_s1 <= 1'b0;
						state_q    <= ST_RESP;
					end
				end
				ST_MOVE: begin
					mv_vld_s1 <= mv_issue_q;
					if (mv_issue_q && mv_end) begin
						mv_issue_q <= 1'b0;
					end
					if (!mv_issue_q && mv_vld_s1) begin
						if (ins_dir) begin
							state_q <= ST_PUT;
						end else begin
							occ_q   <= occ_q - CW'(1);
							state_q <= ST_RESP;
						end
					end
				end
				ST_PUT: begin
					occ_q   <= occ_q + CW'(1);
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: request fields, result fields and move pointers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					kind_q   <= req_kind;
					key_q    <= req.start_epoch;
					cnt_q    <= req.epoch_count;
					hit_q    <= 1'b0;
					pos_q    <= '0;
					fcount_q <= '0;
					status_q <= ert_pkg::STATUS_OK;
					src_q    <= last_idx[IW-1:0];
					if (req_kind == ert_pkg::KIND_INSERT && occ_q == OCC_FULL) begin
						status_q <= ert_pkg::STATUS_FULL;
					end else if (req_kind == ert_pkg::KIND_REMOVE && occ_q == '0) begin
						status_q <= ert_pkg::STATUS_NOT_FOUND;
					end
				end
			end
			ST_SCAN: begin
				if (scan_issue) begin
					cmp_idx_s1 <= rd_idx_q[IW-1:0];
				end
				if (cmp_vld_s1 && match) begin
					hit_q <= 1'b1;
					pos_q <= cmp_idx_s1;
					src_q <= cmp_idx_s1 + IW'(1);
					if (kind_q == ert_pkg::KIND_LOOKUP) begin
						fcount_q <= rd_data_s1.len;
					end
				end else if (cmp_vld_s1 && cmp_last && kind_q == ert_pkg::KIND_REMOVE) begin
					status_q <= ert_pkg::STATUS_NOT_FOUND;
				end
			end
			ST_MOVE: begin
				if (mv_issue_q) begin
					mv_dst_s1 <= ins_dir ? src_q + IW'(1) : src_q - IW'(1);
					if (!mv_end) begin
						src_q <= ins_dir ? src_q - IW'(1) : src_q + IW'(1);
					end
				end
			end
			ST_PUT, ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_hit_q    <= hit_q;
			out_status_q <= status_q;
			out_pos_q    <= pos_wide[ert_pkg::POS_W-1:0];
			out_count_q  <= fcount_q;
		end
	end

	assign req.ready          = state_q == ST_IDLE;
	assign rsp.valid          = out_vld_q;
	assign rsp.hit            = out_hit_q;
	assign rsp.status         = out_status_q;
	assign rsp.found_position = out_pos_q;
	assign rsp.found_count    = out_count_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("occupancy beyond table size");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q != $past(occ_q) |-> occ_q == $past(occ_q) + CW'(1) ||
			occ_q == $past(occ_q) - CW'(1))
		else $error("occupancy moved by more than one");

	a_move_no_put: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUT |-> !mv_vld_s1)
		else $error("move write collides with front write");

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q) == ST_RESP)
		else $error("result beat raised outside response state");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second request taken while first in flight");

endmodule
